>>> rtl/phc_pkg.sv
// shared types and constants for the profile hash counter
package phc_pkg;

	localparam int KeyBits = 32;
	localparam int PcBits = 32;
	localparam int IncBits = 16;
	localparam int IdxOutBits = 12;
	localparam int CntOutBits = 48;
	localparam int UsedOutBits = 13;

	typedef struct packed {
		logic [IncBits-1:0] increment;
		logic [PcBits-1:0]  block_pc;
		logic [KeyBits-1:0] method_key;
	} phc_item_t;

	typedef struct packed {
		logic [UsedOutBits-1:0] entries_used;
		logic                   table_full;
		logic                   new_entry;
		logic [CntOutBits-1:0]  slot_count;
		logic [IdxOutBits-1:0]  slot_index;
	} phc_result_t;

endpackage

>>> rtl/profile_hash_counter.sv
// top level of the profile hash counter
// input stream s_axis: tdata holds method_key, block_pc, increment (80 bits)
// output stream m_axis: tdata holds slot_index, slot_count, new_entry,
// table_full, entries_used (75 bits, zero padded to 80)
// the front multiplies key by pc and reduces it to the home slot
// (by masking for power-of-two tables, by reciprocal multiplication for others), then queues the item
// in a two-entry queue; the back probes the slot ram linearly
// each probed slot takes a ram read state, then a compare and write state
// an item with a free or matching home slot needs a single probe in the back;
// an item probes at most TABLE_ENTRIES slots and reports table_full if none fits
// after reset the back clears the ram one slot per cycle,
// every slot in turn, before it takes any item; the front still fills
// the queue meanwhile
// the result is held in a register until taken; a stalled receiver stops
// the back, and the front keeps accepting until the queue and its input stage are full
module profile_hash_counter #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int COUNT_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // method_key, block_pc, increment
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata   // slot_index, slot_count, new_entry, table_full, entries_used
);
	import phc_pkg::*;

	localparam int IdxBits = $clog2(TABLE_ENTRIES);

	phc_item_t          in_item;
	phc_item_t          q_item;
	logic               q_valid;
	logic               q_ready;
	logic [IdxBits-1:0] q_home;
	phc_result_t        res;

	assign in_item.method_key = s_axis_tdata[31:0];
	assign in_item.block_pc   = s_axis_tdata[63:32];
	assign in_item.increment  = s_axis_tdata[79:64];

	phc_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_item (in_item),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item),
		.q_home  (q_home)
	);

	phc_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item),
		.q_home   (q_home),
		.res_valid(m_axis_tvalid),
		.res_ready(m_axis_tready),
		.res      (res)
	);

	assign m_axis_tdata = {5'd0, res.entries_used, res.table_full, res.new_entry,
		res.slot_count, res.slot_index};

endmodule

>>> rtl/phc_ram.sv
// generic single-port ram with registered read
module phc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> rtl/phc_front.sv
// front end: accepts items, computes the home slot, feeds the queue
module phc_front #(
	parameter int TABLE_ENTRIES = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  phc_pkg::phc_item_t               in_item,
	output logic                             q_valid,
	input  logic                             q_ready,
	output phc_pkg::phc_item_t               q_item,
	output logic [$clog2(TABLE_ENTRIES)-1:0] q_home
);
	import phc_pkg::*;

	localparam int IdxBits = $clog2(TABLE_ENTRIES);
	localparam int QDepth = 2;
	localparam int RecipShift = KeyBits + IdxBits;
	localparam logic [63:0] RecipFull =
		((64'd1 << RecipShift) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
	localparam logic [KeyBits-1:0] RecipLo = RecipFull[KeyBits-1:0];
	localparam logic RecipHi = RecipFull[KeyBits];

	logic              s1_valid_q;
	phc_item_t         item_s1;
	logic [KeyBits-1:0] prod_s1;
	logic [IdxBits-1:0] home_mod;
	logic [KeyBits-1:0] rem_q;
	logic [KeyBits-1:0] modulus;
	logic              mod_busy_q;
	logic [5:0]        mod_step_q;
	logic [2*KeyBits-1:0] mul_q;
	logic [KeyBits-1:0]   quot_q;
	logic [2*KeyBits:0]   recip_sum;
	logic [2*KeyBits:0]   recip_shr;

	phc_item_t          fifo_item_q [QDepth];
	logic [IdxBits-1:0] fifo_home_q [QDepth];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               push;
	logic               pop;
	logic               s1_done;

	assign modulus = KeyBits'(TABLE_ENTRIES);

	// reciprocal multiplication for non power-of-two tables
	assign recip_sum = {1'b0, mul_q} + (RecipHi ? {1'b0, prod_s1, {KeyBits{1'b0}}} : '0);
	assign recip_shr = recip_sum >> RecipShift;

	always_comb begin
		if ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0) begin
			home_mod = prod_s1[IdxBits-1:0];
		end else begin
			home_mod = rem_q[IdxBits-1:0];
		end
	end

	assign s1_done = s1_valid_q &&
		(((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0) || !mod_busy_q);
	assign push = s1_done && (cnt_q != 2'(QDepth));
	assign in_ready = !s1_valid_q;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			mod_busy_q <= 1'b0;
			mod_step_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				s1_valid_q <= 1'b1;
				mod_busy_q <= 1'b1;
				mod_step_q <= '0;
			end else if (push) begin
				s1_valid_q <= 1'b0;
			end
			if (mod_busy_q) begin
				if (mod_step_q == 6'd2) begin
					mod_busy_q <= 1'b0;
				end
				mod_step_q <= mod_step_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
			prod_s1 <= in_item.method_key * in_item.block_pc;
			rem_q <= '0;
		end else if (mod_busy_q) begin
			case (mod_step_q)
				6'd0: begin
					mul_q <= 64'(prod_s1) * 64'(RecipLo);
				end
				6'd1: begin
					quot_q <= recip_shr[KeyBits-1:0];
				end
				default: begin
					rem_q <= prod_s1 - quot_q * modulus;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_item_q[wr_ptr_q] <= item_s1;
			fifo_home_q[wr_ptr_q] <= home_mod;
		end
	end

	assign q_valid = (cnt_q != 2'd0);
	assign q_item = fifo_item_q[rd_ptr_q];
	assign q_home = fifo_home_q[rd_ptr_q];

endmodule

>>> rtl/phc_back.sv
// back end: clear sweep, linear probe, update and result register
module phc_back #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int COUNT_BITS = 48
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	output logic                             q_ready,
	input  phc_pkg::phc_item_t               q_item,
	input  logic [$clog2(TABLE_ENTRIES)-1:0] q_home,
	output logic                             res_valid,
	input  logic                             res_ready,
	output phc_pkg::phc_result_t             res
);
	import phc_pkg::*;

	localparam int IdxBits = $clog2(TABLE_ENTRIES);
	localparam int NBits = $clog2(TABLE_ENTRIES + 1);
	localparam int WordBits = KeyBits + PcBits + COUNT_BITS;

	localparam logic [2:0] StClear = 3'd0;
	localparam logic [2:0] StIdle  = 3'd1;
	localparam logic [2:0] StRead  = 3'd2;
	localparam logic [2:0] StCheck = 3'd3;
	localparam logic [2:0] StOut   = 3'd4;

	logic [2:0]          state_q;
	logic [IdxBits-1:0]  pos_q;
	logic [NBits-1:0]    probes_q;
	logic [NBits-1:0]    used_q;
	phc_item_t           item_q;
	logic                we;
	logic [IdxBits-1:0]  addr;
	logic [WordBits-1:0] wdata;
	logic [WordBits-1:0] rdata;
	logic [KeyBits-1:0]  rd_key;
	logic [PcBits-1:0]   rd_pc;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [COUNT_BITS:0]   sum;
	logic [COUNT_BITS-1:0] new_cnt;
	logic [COUNT_BITS-1:0] inc_ext;
	logic                  empty;
	logic                  hit;
	phc_result_t           res_q;

	assign rd_key = rdata[WordBits-1 -: KeyBits];
	assign rd_pc  = rdata[COUNT_BITS +: PcBits];
	assign rd_cnt = rdata[COUNT_BITS-1:0];
	assign empty = (rd_key == '0);
	assign hit = empty || (rd_key == item_q.method_key && rd_pc == item_q.block_pc);
	assign inc_ext = COUNT_BITS'(item_q.increment);
	assign sum = {1'b0, (empty ? {COUNT_BITS{1'b0}} : rd_cnt)} + {1'b0, inc_ext};
	assign new_cnt = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];

	always_comb begin
		we = 1'b0;
		addr = pos_q;
		wdata = {item_q.method_key, item_q.block_pc, new_cnt};
		case (state_q)
			StClear: begin
				we = 1'b1;
				wdata = '0;
			end
			StCheck: begin
				we = hit;
			end
			default: begin
			end
		endcase
	end

	phc_ram #(.WIDTH(WordBits), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk  (clk),
		.we   (we),
		.addr (addr),
		.wdata(wdata),
		.rdata(rdata)
	);

	assign q_ready = (state_q == StIdle);
	assign res_valid = (state_q == StOut);
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StClear;
			pos_q <= '0;
			probes_q <= '0;
			used_q <= '0;
		end else begin
			case (state_q)
				StClear: begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == IdxBits'(TABLE_ENTRIES - 1)) begin
						pos_q <= '0;
						state_q <= StIdle;
					end
				end
				StIdle: begin
					if (q_valid) begin
						pos_q <= q_home;
						probes_q <= '0;
						state_q <= (q_item.method_key == '0) ? StOut : StRead;
					end
				end
				StRead: begin
					state_q <= StCheck;
				end
				StCheck: begin
					if (hit) begin
						if (empty) begin
							used_q <= used_q + 1'b1;
						end
						state_q <= StOut;
					end else if (probes_q == NBits'(TABLE_ENTRIES - 1)) begin
						state_q <= StOut;
					end else begin
						probes_q <= probes_q + 1'b1;
						pos_q <= (pos_q == IdxBits'(TABLE_ENTRIES - 1)) ? '0 : pos_q + 1'b1;
						state_q <= StRead;
					end
				end
				StOut: begin
					if (res_ready) begin
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == StIdle && q_valid) begin
			item_q <= q_item;
			res_q.slot_index <= IdxOutBits'(q_home);
			res_q.slot_count <= '0;
			res_q.new_entry <= 1'b0;
			res_q.table_full <= 1'b0;
			res_q.entries_used <= UsedOutBits'(used_q);
		end else if (state_q == StCheck) begin
			if (hit) begin
				res_q.slot_index <= IdxOutBits'(pos_q);
				res_q.slot_count <= CntOutBits'(new_cnt);
				res_q.new_entry <= empty;
				res_q.entries_used <= UsedOutBits'(used_q + NBits'(empty));
			end else if (probes_q == NBits'(TABLE_ENTRIES - 1)) begin
				res_q.slot_index <= '0;
				res_q.table_full <= 1'b1;
			end
		end
	end

endmodule

>>> bench/profile_hash_counter_checker.sv
// checker for the profile hash counter: predicts and compares each result transaction
`timescale 1ns / 100ps

module profile_hash_counter_checker #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int COUNT_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [79:0] m_axis_tdata,
	output int          error_count,
	output int          pending
);
	import phc_pkg::*;

	logic [KeyBits-1:0]    tbl_key [TABLE_ENTRIES];
	logic [PcBits-1:0]     tbl_pc [TABLE_ENTRIES];
	logic [COUNT_BITS-1:0] tbl_total [TABLE_ENTRIES];
	int                    used_slots;
	phc_result_t           result_queue[$];

	function automatic phc_result_t update_table(phc_item_t item);
		phc_result_t r;
		logic [31:0] prod;
		int home;
		int pos;
		int hit;
		logic [COUNT_BITS:0] sum;
		logic [COUNT_BITS:0] top;
		r = '0;
		prod = item.method_key * item.block_pc;
		home = prod % TABLE_ENTRIES;
		top = {1'b0, {COUNT_BITS{1'b1}}};
		if (item.method_key == 0) begin
			r.slot_index = home[IdxOutBits-1:0];
			r.entries_used = used_slots[UsedOutBits-1:0];
			return r;
		end
		pos = home;
		hit = 0;
		for (int n = 0; n < TABLE_ENTRIES; n++) begin
			if (tbl_key[pos] == 0 ||
					(tbl_key[pos] == item.method_key && tbl_pc[pos] == item.block_pc)) begin
				hit = 1;
				break;
			end
			pos = (pos + 1) % TABLE_ENTRIES;
		end
		if (!hit) begin
			r.table_full = 1'b1;
			r.entries_used = used_slots[UsedOutBits-1:0];
			return r;
		end
		if (tbl_key[pos] == 0) begin
			tbl_key[pos] = item.method_key;
			tbl_pc[pos] = item.block_pc;
			tbl_total[pos] = COUNT_BITS'(item.increment);
			used_slots++;
			r.new_entry = 1'b1;
		end else begin
			sum = {1'b0, tbl_total[pos]} + (COUNT_BITS + 1)'(item.increment);
			tbl_total[pos] = (sum > top) ? top[COUNT_BITS-1:0] : sum[COUNT_BITS-1:0];
		end
		r.slot_index = pos[IdxOutBits-1:0];
		r.slot_count = CntOutBits'(tbl_total[pos]);
		r.entries_used = used_slots[UsedOutBits-1:0];
		return r;
	endfunction

	assign pending = result_queue.size();

	initial begin
		error_count = 0;
		used_slots = 0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			tbl_key[i] = '0;
			tbl_pc[i] = '0;
			tbl_total[i] = '0;
		end
	end

	always @(posedge clk) begin
		phc_result_t got;
		phc_result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				result_queue.push_back(update_table(phc_item_t'(s_axis_tdata)));
			if (m_axis_tvalid && m_axis_tready) begin
				got = phc_result_t'(m_axis_tdata[74:0]);
				if (result_queue.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					error_count++;
				end else begin
					want = result_queue.pop_front();
					if (got.slot_index !== want.slot_index) begin
						$display("%0t: slot_index expected %0d actual %0d", $time,
							want.slot_index, got.slot_index);
						error_count++;
					end
					if (got.slot_count !== want.slot_count) begin
						$display("%0t: slot_count expected %0d actual %0d", $time,
							want.slot_count, got.slot_count);
						error_count++;
					end
					if (got.new_entry !== want.new_entry) begin
						$display("%0t: new_entry expected %0d actual %0d", $time,
							want.new_entry, got.new_entry);
						error_count++;
					end
					if (got.table_full !== want.table_full) begin
						$display("%0t: table_full expected %0d actual %0d", $time,
							want.table_full, got.table_full);
						error_count++;
					end
					if (got.entries_used !== want.entries_used) begin
						$display("%0t: entries_used expected %0d actual %0d", $time,
							want.entries_used, got.entries_used);
						error_count++;
					end
				end
			end
		end
	end

endmodule

>>> bench/profile_hash_counter_test.sv
// testbench top for the profile hash counter: stimulus, idling phases and verdict
`timescale 1ns / 100ps

module profile_hash_counter_test;
	import phc_pkg::*;

	localparam int WatchdogLimit = 200000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;
	int          error_count;
	int          pending;
	int          send_idle_pct;
	int          recv_stall_pct;
	bit          hold_off;
	int          quiet_cycles;
	logic [31:0] hot_keys [8];
	logic [31:0] hot_pcs [8];

	profile_hash_counter u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	profile_hash_counter_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.error_count(error_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls at random, or holds off entirely during pressure
	always @(negedge clk) begin
		if (hold_off)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_item(logic [31:0] key, logic [31:0] pc, logic [15:0] inc);
		phc_item_t item;
		item.method_key = key;
		item.block_pc = pc;
		item.increment = inc;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= item;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random(int count);
		int sel;
		int h;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			h = $urandom_range(7);
			if (sel < 45)
				send_item(hot_keys[h], hot_pcs[h], 16'($urandom));
			else if (sel < 50)
				send_item(hot_keys[h], hot_pcs[h], 16'hffff);
			else if (sel < 55)
				send_item(32'd0, $urandom, 16'($urandom));
			else if (sel < 65)
				send_item($urandom_range(3, 1), $urandom_range(15), 16'($urandom));
			else
				send_item($urandom | 32'd1 << $urandom_range(31), $urandom, 16'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 1'b0;
		quiet_cycles = 0;
		for (int i = 0; i < 8; i++) begin
			hot_keys[i] = $urandom | 32'd1;
			hot_pcs[i] = $urandom;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, reserved key, collisions, repeat hits
		send_item(32'hffffffff, 32'hffffffff, 16'hffff);
		send_item(32'hffffffff, 32'hffffffff, 16'hffff);
		send_item(32'd1, 32'd0, 16'd0);
		send_item(32'd1, 32'd0, 16'd5);
		send_item(32'd0, 32'd0, 16'd7);
		send_item(32'd0, 32'hffffffff, 16'hffff);
		send_item(32'd2, 32'd0, 16'd1);
		send_item(32'd3, 32'd0, 16'd1);
		send_item(32'd4096, 32'd1, 16'd9);
		send_item(32'd8192, 32'd1, 16'd9);
		send_item(32'd1, 32'd4095, 16'd3);
		send_item(32'd4095, 32'd1, 16'd3);
		send_item(32'd1, 32'd4095, 16'hffff);
		send_item(32'h80000000, 32'h80000001, 16'h8000);
		send_item(32'h55555555, 32'haaaaaaaa, 16'h5555);
		send_item(32'haaaaaaaa, 32'h55555555, 16'haaaa);
		send_item(32'h80000000, 32'h80000001, 16'h8000);

		send_random(200);
		send_idle_pct = 65;
		send_random(200);
		send_idle_pct = 0;
		recv_stall_pct = 65;
		send_random(200);
		send_idle_pct = 37;
		recv_stall_pct = 37;
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			send_random(50);
		join
		send_random(180);
		s_axis_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (10000) @(posedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
